/* rtl/trdq_pkg.sv */
// Package for the thread record deque: request, response and record types,
// request and status codes, and the cell control struct. No dependencies.
package trdq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_BACK   = 3'd3;
	localparam logic [2:0] FN_SEARCH     = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] rec_id;
		logic [31:0] thread_data;
	} req_t;

	typedef struct packed {
		logic [31:0] out_id;
		logic [31:0] out_data;
		logic        found;
		logic [4:0]  occupancy;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] data;
	} rec_t;

	// Per-cell control: shift toward the back, shift toward the front,
	// load the incoming record, and whether the cell holds a live record.
	typedef struct packed {
		logic shift_r;
		logic shift_l;
		logic load;
		logic held;
	} cell_ctl_t;

endpackage

/* rtl/trdq_cell.sv */
// One storage cell of the thread record deque: holds one record, takes it
// from either neighbor or from the request, and matches its id against a key.
// Depends on trdq_pkg.
module trdq_cell (
	input  logic                 clk,
	input  trdq_pkg::cell_ctl_t  ctl,
	input  trdq_pkg::rec_t       new_rec,
	input  trdq_pkg::rec_t       left_rec,
	input  trdq_pkg::rec_t       right_rec,
	input  logic [31:0]          key,
	output trdq_pkg::rec_t       rec,
	output logic                 hit
);

	trdq_pkg::rec_t rec_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_r) begin
			rec_q <= left_rec;
		end else if (ctl.shift_l) begin
			rec_q <= right_rec;
		end else if (ctl.load) begin
			rec_q <= new_rec;
		end
	end

	assign rec = rec_q;
	assign hit = ctl.held && (rec_q.id == key);

endmodule

/* rtl/thread_record_deque_top.sv */
// Top level of the thread record deque: a row of record cells kept in order
// from front to back, a record counter, and the registered response.
// Depends on trdq_pkg and trdq_cell.

// A request is taken at every clock edge where start is high and busy is low;
// busy stays low, so a new request may follow in every cycle. Each request
// yields one response on rsp, marked by done for exactly one cycle, in the
// cycle right after the request. The receiver cannot stall the response, so
// take it when done is high. Records sit in a row of DEPTH cells with the
// front record in cell 0: push front and pop front shift the whole row by
// one cell, push back loads the cell just past the last record, pop back
// reads that last record, and a search compares every held cell against
// the key at once. Pops on an empty deque report status empty and change
// nothing; pushes on a full deque report status full and drop the record.
// occupancy gives the number of records held after the request.
module thread_record_deque_top #(
	parameter int DEPTH = trdq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  trdq_pkg::req_t req,
	output logic           done,
	output trdq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic [CW-1:0]        last_pos;
	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 do_push_f;
	logic                 do_push_b;
	logic                 do_pop_f;
	logic                 do_pop_b;
	trdq_pkg::rec_t       new_rec;
	trdq_pkg::rec_t       cell_rec [DEPTH];
	trdq_pkg::cell_ctl_t  cell_ctl [DEPTH];
	logic [DEPTH-1:0]     cell_hit;
	trdq_pkg::rsp_t       rsp_d;
	trdq_pkg::rsp_t       rsp_s1;
	logic                 done_q;

	// Every request completes in one update, so never hold off a transfer.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign last_pos = count_q - CW'(1);
	assign new_rec  = '{id: req.rec_id, data: req.thread_data};

	assign do_push_f = accept && (req.func == trdq_pkg::FN_PUSH_FRONT) && !full;
	assign do_push_b = accept && (req.func == trdq_pkg::FN_PUSH_BACK) && !full;
	assign do_pop_f  = accept && (req.func == trdq_pkg::FN_POP_FRONT) && !empty;
	assign do_pop_b  = accept && (req.func == trdq_pkg::FN_POP_BACK) && !empty;

	// Cell row: cell 0 is the front. Shifting toward the back feeds cell 0
	// from the request; the last cell refills itself on a shift to the front.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		trdq_pkg::rec_t left_rec;
		trdq_pkg::rec_t right_rec;

		if (i == 0) begin : g_first
			assign left_rec = new_rec;
		end else begin : g_inner_l
			assign left_rec = cell_rec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_rec = cell_rec[i];
		end else begin : g_inner_r
			assign right_rec = cell_rec[i+1];
		end

		assign cell_ctl[i].shift_r = do_push_f;
		assign cell_ctl[i].shift_l = do_pop_f;
		assign cell_ctl[i].load    = do_push_b && (count_q == CW'(i));
		assign cell_ctl[i].held    = (CW'(i) < count_q);

		trdq_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.key       (req.rec_id),
			.rec       (cell_rec[i]),
			.hit       (cell_hit[i])
		);
	end

	// Advance the counter and build the response for this request.
	always_comb begin
		count_d = count_q;
		rsp_d   = '0;
		unique case (req.func) inside
			trdq_pkg::FN_PUSH_FRONT, trdq_pkg::FN_PUSH_BACK: begin
				if (full) begin
					rsp_d.status = trdq_pkg::ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			trdq_pkg::FN_POP_FRONT: begin
				if (empty) begin
					rsp_d.status = trdq_pkg::ST_EMPTY;
				end else begin
					rsp_d.out_id   = cell_rec[0].id;
					rsp_d.out_data = cell_rec[0].data;
					count_d        = last_pos;
				end
			end
			trdq_pkg::FN_POP_BACK: begin
				if (empty) begin
					rsp_d.status = trdq_pkg::ST_EMPTY;
				end else begin
					rsp_d.out_id   = cell_rec[last_pos[IW-1:0]].id;
					rsp_d.out_data = cell_rec[last_pos[IW-1:0]].data;
					count_d        = last_pos;
				end
			end
			trdq_pkg::FN_SEARCH: begin
				rsp_d.found = |cell_hit;
			end
			default: begin
				// Unknown request: report the count and change nothing.
			end
		endcase
		rsp_d.occupancy = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// Register the response on each transfer; it holds until the next transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_s1;

endmodule
